// ===== rtl/core/epc_pkg.sv =====
// shared constants, state type and month length table for epoch_to_calendar
package epc_pkg;

    localparam int unsigned EpochW    = 32;
    localparam int unsigned RemW      = 17;
    localparam int unsigned OpW       = RemW + 1;
    localparam int unsigned DaysW     = 16;
    localparam int unsigned YearW     = 12;
    localparam int unsigned MonthW    = 4;
    localparam int unsigned DayW      = 5;
    localparam int unsigned HourW     = 5;
    localparam int unsigned MinuteW   = 6;
    localparam int unsigned SecondW   = 6;
    localparam int unsigned OutW      = 40;
    localparam int unsigned CntW      = 5;

    localparam logic [OpW-1:0]     SecsPerDay  = OpW'(86400);
    localparam logic [OpW-1:0]     SecsPerHour = OpW'(3600);
    localparam logic [OpW-1:0]     SecsPerMin  = OpW'(60);
    localparam logic [YearW-1:0]   BaseYear    = YearW'(1970);
    localparam logic [6:0]         BaseMod100  = 7'd70;
    localparam logic [8:0]         BaseMod400  = 9'd370;
    localparam logic [1:0]         BaseMod4    = 2'd2;
    localparam logic [8:0]         LeapYearLen = 9'd366;
    localparam logic [8:0]         YearLen     = 9'd365;
    localparam logic [MonthW-1:0]  LastMonth   = MonthW'(11);
    localparam logic [MonthW-1:0]  February    = MonthW'(1);

    localparam logic [CntW-1:0]    DayDivSteps  = CntW'(31);
    localparam logic [CntW-1:0]    HourDivSteps = CntW'(16);
    localparam logic [CntW-1:0]    MinDivSteps  = CntW'(11);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_DIV_DAY  = 7'b0000010,
        ST_DIV_HOUR = 7'b0000100,
        ST_DIV_MIN  = 7'b0001000,
        ST_YEAR     = 7'b0010000,
        ST_MONTH    = 7'b0100000,
        ST_DONE     = 7'b1000000
    } epc_state_t;

    function automatic logic [4:0] month_len(input logic [MonthW-1:0] mon, input logic leap);
        logic [4:0] len;
        begin
            case (mon)
                4'd0:    len = 5'd31;
                4'd1:    len = leap ? 5'd29 : 5'd28;
                4'd2:    len = 5'd31;
                4'd3:    len = 5'd30;
                4'd4:    len = 5'd31;
                4'd5:    len = 5'd30;
                4'd6:    len = 5'd31;
                4'd7:    len = 5'd31;
                4'd8:    len = 5'd30;
                4'd9:    len = 5'd31;
                4'd10:   len = 5'd30;
                4'd11:   len = 5'd31;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// ===== rtl/core/epoch_to_calendar.sv =====
// epoch seconds to gregorian date and time, one shared subtract-compare unit
//
// Converts a 32-bit unsigned count of seconds since 1970-01-01 00:00:00 into
// year, month, day, hour, minute and second. A single 18-bit subtract/compare
// unit does all arithmetic under a small sequencer: 32 restoring-division
// steps by 86400, 17 steps by 3600, 12 steps by 60, then one compare per
// year (each whole year taken off plus the closing compare, up to 137) and one
// per month (up to 12), plus an accept state and a result state. The result
// state waits for the output register to free up. One request is worked
// on at a time; s_tready is high while the sequencer is idle, and the next
// request may be taken while the previous result still waits in the output
// register.
module epoch_to_calendar (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [epc_pkg::EpochW-1:0] s_tdata,   // epoch_seconds[31:0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
    // second[37:32], zero[39:38]
    output logic [epc_pkg::OutW-1:0]   m_tdata
);
    import epc_pkg::*;

    epc_state_t           state_reg, state_next;
    logic [EpochW-1:0]    acc_reg, acc_next;
    logic [RemW-1:0]      rem_reg, rem_next;
    logic [CntW-1:0]      cnt_reg, cnt_next;
    logic [DaysW-1:0]     days_reg, days_next;
    logic [YearW-1:0]     year_reg, year_next;
    logic [1:0]           mod4_reg, mod4_next;
    logic [6:0]           mod100_reg, mod100_next;
    logic [8:0]           mod400_reg, mod400_next;
    logic [MonthW-1:0]    mon_reg, mon_next;
    logic [HourW-1:0]     hour_reg, hour_next;
    logic [MinuteW-1:0]   min_reg, min_next;
    logic [SecondW-1:0]   sec_reg, sec_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [OutW-1:0]      m_tdata_reg, m_tdata_next;

    logic [OpW-1:0]       op_a, op_b;
    logic [OpW:0]         diff;
    logic                 ge;
    logic                 leap;
    logic [RemW-1:0]      step_rem;
    logic [EpochW-1:0]    step_acc;
    logic                 out_free;
    logic [DayW-1:0]      day_out;
    logic [MonthW-1:0]    month_out;

    assign leap = ((mod4_reg == 2'd0) && (mod100_reg != 7'd0)) || (mod400_reg == 9'd0);

    // shared subtract/compare unit
    always_comb
    begin
        op_a = {rem_reg, acc_reg[EpochW-1]};
        op_b = SecsPerDay;
        unique case (state_reg)
            ST_DIV_DAY:  op_b = SecsPerDay;
            ST_DIV_HOUR: op_b = SecsPerHour;
            ST_DIV_MIN:  op_b = SecsPerMin;
            ST_YEAR:
            begin
                op_a = OpW'(days_reg);
                op_b = leap ? OpW'(LeapYearLen) : OpW'(YearLen);
            end
            ST_MONTH:
            begin
                op_a = OpW'(days_reg);
                op_b = OpW'(month_len(mon_reg, leap));
            end
            default:
            begin
                op_a = {rem_reg, acc_reg[EpochW-1]};
                op_b = SecsPerDay;
            end
        endcase
    end

    assign diff     = {1'b0, op_a} - {1'b0, op_b};
    assign ge       = ~diff[OpW];
    assign step_rem = ge ? diff[RemW-1:0] : op_a[RemW-1:0];
    assign step_acc = {acc_reg[EpochW-2:0], ge};
    assign out_free = !m_tvalid_reg || m_tready;
    assign day_out   = DayW'(days_reg) + DayW'(1);
    assign month_out = mon_reg + MonthW'(1);

    always_comb
    begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        days_next     = days_reg;
        year_next     = year_reg;
        mod4_next     = mod4_reg;
        mod100_next   = mod100_reg;
        mod400_next   = mod400_reg;
        mon_next      = mon_reg;
        hour_next     = hour_reg;
        min_next      = min_reg;
        sec_next      = sec_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    acc_next   = s_tdata;
                    rem_next   = '0;
                    cnt_next   = DayDivSteps;
                    state_next = ST_DIV_DAY;
                end
            end
            ST_DIV_DAY:
            begin
                acc_next = step_acc;
                rem_next = step_rem;
                cnt_next = cnt_reg - CntW'(1);
                if (cnt_reg == '0)
                begin
                    days_next  = step_acc[DaysW-1:0];
                    // left-align time of day for the next division
                    acc_next   = {step_rem, {(EpochW-RemW){1'b0}}};
                    rem_next   = '0;
                    cnt_next   = HourDivSteps;
                    state_next = ST_DIV_HOUR;
                end
            end
            ST_DIV_HOUR:
            begin
                acc_next = step_acc;
                rem_next = step_rem;
                cnt_next = cnt_reg - CntW'(1);
                if (cnt_reg == '0)
                begin
                    hour_next  = step_acc[HourW-1:0];
                    acc_next   = {step_rem[11:0], {(EpochW-12){1'b0}}};
                    rem_next   = '0;
                    cnt_next   = MinDivSteps;
                    state_next = ST_DIV_MIN;
                end
            end
            ST_DIV_MIN:
            begin
                acc_next = step_acc;
                rem_next = step_rem;
                cnt_next = cnt_reg - CntW'(1);
                if (cnt_reg == '0)
                begin
                    min_next    = step_acc[MinuteW-1:0];
                    sec_next    = step_rem[SecondW-1:0];
                    year_next   = BaseYear;
                    mod4_next   = BaseMod4;
                    mod100_next = BaseMod100;
                    mod400_next = BaseMod400;
                    state_next  = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                if (ge)
                begin
                    days_next   = diff[DaysW-1:0];
                    year_next   = year_reg + YearW'(1);
                    mod4_next   = mod4_reg + 2'd1;
                    mod100_next = (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
                    mod400_next = (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
                end
                else
                begin
                    mon_next   = '0;
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                if (ge && (mon_reg != LastMonth))
                begin
                    days_next = diff[DaysW-1:0];
                    mon_next  = mon_reg + MonthW'(1);
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tdata_next  = {2'b00, sec_reg, min_reg, hour_reg, day_out,
                                     month_out, year_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        days_reg    <= days_next;
        year_reg    <= year_next;
        mod4_reg    <= mod4_next;
        mod100_reg  <= mod100_next;
        mod400_reg  <= mod400_next;
        mon_reg     <= mon_next;
        hour_reg    <= hour_next;
        min_reg     <= min_next;
        sec_reg     <= sec_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // year search never runs past the last representable year
    a_year_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_YEAR) |-> (year_reg <= YearW'(2106)))
        else $error("year search ran past 2106");

    // the mod-4 counter tracks the low bits of the year
    a_mod4_track: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_YEAR || state_reg == ST_MONTH) |-> (mod4_reg == year_reg[1:0]))
        else $error("leap counter out of step with year");

    // month search stays within the year and its remaining days fit a year
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MONTH) |-> ((mon_reg <= LastMonth) && (days_reg < DaysW'(366))))
        else $error("month search out of range");

    // a finished conversion lands in the output register on the next edge
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("finished conversion not presented");
`endif

endmodule
